// ===== rtl/core/lrf_pkg.sv =====
`default_nettype none

package lrf_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int IN_BITS        = 24;
   localparam int OUT_BITS       = 32;
   localparam int OUT_PAD        = OUT_BITS - SAMPLE_BITS;
   localparam int FRAC_BITS      = 16;
   localparam int PHASE_BITS     = 48;
   localparam int INT_BITS       = PHASE_BITS - FRAC_BITS;
   localparam int COUNT_BITS     = 32;
   localparam int STEP_BITS      = 18;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DIGIT_BITS     = 4;
   localparam int INTERP_DIGITS  = FRAC_BITS / DIGIT_BITS;
   localparam int GAIN_SHIFT     = 8;
   localparam int FADE_DIGITS    = GAIN_SHIFT / DIGIT_BITS;
   localparam int FADE_LENGTH    = 1 << GAIN_SHIFT;
   localparam int MAX_RESULTS    = 4;
   localparam int K_BITS         = $clog2(MAX_RESULTS + 1);
   localparam int DCNT_BITS      = $clog2(INTERP_DIGITS + 1);
   localparam int ACC_BITS       = SAMPLE_BITS + DIGIT_BITS + 2;

   localparam logic [STEP_BITS-1:0]  MIN_STEP          = STEP_BITS'(32768);
   localparam logic [STEP_BITS-1:0]  STEP_RESET        = STEP_BITS'(61656);
   localparam logic [COUNT_BITS-1:0] SOURCE_RESET      = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] OUTPUT_RESET      = COUNT_BITS'(0);
   localparam logic                  STEREO_RESET      = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STEP          = 2'd0,
      CSR_SOURCE_FRAMES = 2'd1,
      CSR_OUTPUT_FRAMES = 2'd2,
      CSR_STEREO_MODE   = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_FADE  = 5'b01000,
      ST_ADV   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/linear_resampler_with_fade_unit.sv =====
`default_nettype none
// A request is taken only while the unit is idle. An interpolated result runs the serial
// multiply over the fraction digits and a copied result skips it; a fade inside the ramp
// adds a second serial multiply pass. Each request yields at most four results.
// The next request is not taken until the last result of the current one has moved to
// the output register, so stalls on rsp_ready hold it back.
// Synchronous reset restores register defaults and clears phase, history and counts.

module linear_resampler_with_fade_unit (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          req_valid,
   output logic                                         req_ready,
   input  wire  signed [lrf_pkg::IN_BITS-1:0]           req_sample_left,
   input  wire  signed [lrf_pkg::IN_BITS-1:0]           req_sample_right,
   output logic                                         rsp_valid,
   input  wire                                          rsp_ready,
   output logic signed [lrf_pkg::OUT_BITS-1:0]          rsp_out_left,
   output logic signed [lrf_pkg::OUT_BITS-1:0]          rsp_out_right,
   output logic                                         rsp_last_of_run,
   output logic                                         rsp_end_of_track,
   input  wire                                          csr_wen,
   input  wire         [lrf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire         [lrf_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int SW = lrf_pkg::SAMPLE_BITS;

   lrf_pkg::state_type state_ff, state_in;

   logic [lrf_pkg::STEP_BITS-1:0]  step_cfg_ff, step_cfg_in;
   logic [lrf_pkg::COUNT_BITS-1:0] src_frames_ff, src_frames_in;
   logic [lrf_pkg::COUNT_BITS-1:0] out_frames_ff, out_frames_in;
   logic                           stereo_ff, stereo_in;

   logic [lrf_pkg::PHASE_BITS-1:0] phase_ff, phase_in;
   logic signed [SW-1:0]           prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic [lrf_pkg::COUNT_BITS-1:0] index_ff, index_in;
   logic [lrf_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [lrf_pkg::K_BITS-1:0]     k_ff, k_in;
   logic                           copy_ff, copy_in;
   logic                           pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic signed [SW-1:0]                 cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic                                 final_ff, final_in;
   logic [lrf_pkg::COUNT_BITS-1:0]       fstart_ff, fstart_in;
   logic [lrf_pkg::STEP_BITS-1:0]        step_ff, step_in;
   logic signed [SW:0]                   mul_l_ff, mul_l_in, mul_r_ff, mul_r_in;
   logic signed [lrf_pkg::ACC_BITS-1:0]  acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   logic [lrf_pkg::FRAC_BITS-1:0]        digits_ff, digits_in;
   logic [lrf_pkg::DCNT_BITS-1:0]        dcnt_ff, dcnt_in;
   logic                                 mul_fade_ff, mul_fade_in;
   logic                                 interp_ff, interp_in;
   logic signed [SW-1:0]                 val_l_ff, val_l_in, val_r_ff, val_r_in;
   logic signed [lrf_pkg::OUT_BITS-1:0]  rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic                                 rsp_last_ff, rsp_last_in, rsp_end_ff, rsp_end_in;

   logic [lrf_pkg::INT_BITS-1:0]         phase_int;
   logic [lrf_pkg::COUNT_BITS-1:0]       index_m1;
   logic                                 interp_hit, copy_hit, more_room, next_exists, out_free;
   logic signed [lrf_pkg::DIGIT_BITS:0]  digit_s;
   logic signed [lrf_pkg::ACC_BITS-1:0]  prod_l, prod_r, sum_l, sum_r, shr_l, shr_r;
   logic signed [SW:0]                   isum_l, isum_r;
   logic signed [SW-1:0]                 base_l, base_r;
   logic [lrf_pkg::COUNT_BITS:0]         off_full;
   logic                                 off_big;
   logic [lrf_pkg::GAIN_SHIFT-1:0]       gain;

   assign phase_int   = phase_ff[lrf_pkg::PHASE_BITS-1:lrf_pkg::FRAC_BITS];
   assign index_m1    = index_ff - lrf_pkg::COUNT_BITS'(1);
   assign interp_hit  = (index_ff != '0) && (phase_int == index_m1);
   assign copy_hit    = final_ff && (phase_int == index_ff);
   assign more_room   = (k_ff != lrf_pkg::K_BITS'(lrf_pkg::MAX_RESULTS));
   assign next_exists = more_room && (copy_ff ? copy_hit : interp_hit);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign digit_s = $signed({1'b0, digits_ff[lrf_pkg::DIGIT_BITS-1:0]});
   assign prod_l  = mul_l_ff * digit_s;
   assign prod_r  = mul_r_ff * digit_s;
   assign sum_l   = acc_l_ff + prod_l;
   assign sum_r   = acc_r_ff + prod_r;
   assign shr_l   = sum_l >>> lrf_pkg::DIGIT_BITS;
   assign shr_r   = sum_r >>> lrf_pkg::DIGIT_BITS;

   assign isum_l = {prev_l_ff[SW-1], prev_l_ff} + acc_l_ff[SW:0];
   assign isum_r = {prev_r_ff[SW-1], prev_r_ff} + acc_r_ff[SW:0];
   assign base_l = interp_ff ? isum_l[SW-1:0] : val_l_ff;
   assign base_r = interp_ff ? isum_r[SW-1:0] : val_r_ff;

   assign off_full = {1'b0, count_ff} - {1'b0, fstart_ff};
   assign off_big  = (off_full[lrf_pkg::COUNT_BITS-1:lrf_pkg::GAIN_SHIFT] != '0);
   assign gain     = lrf_pkg::GAIN_SHIFT'(0) - off_full[lrf_pkg::GAIN_SHIFT-1:0];

   always_comb begin
      state_in      = state_ff;
      step_cfg_in   = step_cfg_ff;
      src_frames_in = src_frames_ff;
      out_frames_in = out_frames_ff;
      stereo_in     = stereo_ff;
      phase_in      = phase_ff;
      prev_l_in     = prev_l_ff;
      prev_r_in     = prev_r_ff;
      index_in      = index_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      copy_in       = copy_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cur_l_in      = cur_l_ff;
      cur_r_in      = cur_r_ff;
      final_in      = final_ff;
      fstart_in     = fstart_ff;
      step_in       = step_ff;
      mul_l_in      = mul_l_ff;
      mul_r_in      = mul_r_ff;
      acc_l_in      = acc_l_ff;
      acc_r_in      = acc_r_ff;
      digits_in     = digits_ff;
      dcnt_in       = dcnt_ff;
      mul_fade_in   = mul_fade_ff;
      interp_in     = interp_ff;
      val_l_in      = val_l_ff;
      val_r_in      = val_r_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;

      if (csr_wen) begin
         case (lrf_pkg::csr_index_type'(csr_index))
            lrf_pkg::CSR_STEP:          step_cfg_in   = csr_wdata[lrf_pkg::STEP_BITS-1:0];
            lrf_pkg::CSR_SOURCE_FRAMES: src_frames_in = csr_wdata[lrf_pkg::COUNT_BITS-1:0];
            lrf_pkg::CSR_OUTPUT_FRAMES: out_frames_in = csr_wdata[lrf_pkg::COUNT_BITS-1:0];
            lrf_pkg::CSR_STEREO_MODE:   stereo_in     = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         lrf_pkg::ST_IDLE: begin
            if (req_valid) begin
               cur_l_in = req_sample_left[SW-1:0];
               cur_r_in = stereo_ff ? req_sample_right[SW-1:0] : req_sample_left[SW-1:0];
               final_in = (({1'b0, index_ff} + (lrf_pkg::COUNT_BITS+1)'(1))
                           >= {1'b0, src_frames_ff});
               fstart_in = (out_frames_ff > lrf_pkg::COUNT_BITS'(lrf_pkg::FADE_LENGTH))
                         ? out_frames_ff - lrf_pkg::COUNT_BITS'(lrf_pkg::FADE_LENGTH) : '0;
               step_in  = (step_cfg_ff < lrf_pkg::MIN_STEP) ? lrf_pkg::MIN_STEP : step_cfg_ff;
               k_in     = '0;
               copy_in  = 1'b0;
               pend_in  = 1'b0;
               state_in = lrf_pkg::ST_CHECK;
            end
         end
         lrf_pkg::ST_CHECK: begin
            if (!copy_ff && more_room && !interp_hit) begin
               copy_in = 1'b1;
            end else if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_left_in  = {val_l_ff, {lrf_pkg::OUT_PAD{1'b0}}};
                  rsp_right_in = {val_r_ff, {lrf_pkg::OUT_PAD{1'b0}}};
                  rsp_last_in  = !next_exists;
                  rsp_end_in   = !next_exists && final_ff;
                  pend_in      = 1'b0;
               end
               if (next_exists) begin
                  if (copy_ff) begin
                     val_l_in  = cur_l_ff;
                     val_r_in  = cur_r_ff;
                     interp_in = 1'b0;
                     state_in  = lrf_pkg::ST_FADE;
                  end else begin
                     mul_l_in    = {cur_l_ff[SW-1], cur_l_ff} - {prev_l_ff[SW-1], prev_l_ff};
                     mul_r_in    = {cur_r_ff[SW-1], cur_r_ff} - {prev_r_ff[SW-1], prev_r_ff};
                     acc_l_in    = '0;
                     acc_r_in    = '0;
                     digits_in   = phase_ff[lrf_pkg::FRAC_BITS-1:0];
                     dcnt_in     = lrf_pkg::DCNT_BITS'(lrf_pkg::INTERP_DIGITS);
                     mul_fade_in = 1'b0;
                     interp_in   = 1'b1;
                     state_in    = lrf_pkg::ST_MUL;
                  end
               end else begin
                  if (final_ff) begin
                     phase_in  = '0;
                     prev_l_in = '0;
                     prev_r_in = '0;
                     index_in  = '0;
                     count_in  = '0;
                  end else begin
                     prev_l_in = cur_l_ff;
                     prev_r_in = cur_r_ff;
                     index_in  = index_ff + lrf_pkg::COUNT_BITS'(1);
                  end
                  state_in = lrf_pkg::ST_IDLE;
               end
            end
         end
         lrf_pkg::ST_MUL: begin
            acc_l_in  = shr_l;
            acc_r_in  = shr_r;
            digits_in = digits_ff >> lrf_pkg::DIGIT_BITS;
            dcnt_in   = dcnt_ff - lrf_pkg::DCNT_BITS'(1);
            if (dcnt_ff == lrf_pkg::DCNT_BITS'(1)) begin
               if (mul_fade_ff) begin
                  val_l_in = shr_l[SW-1:0];
                  val_r_in = shr_r[SW-1:0];
                  state_in = lrf_pkg::ST_ADV;
               end else begin
                  state_in = lrf_pkg::ST_FADE;
               end
            end
         end
         lrf_pkg::ST_FADE: begin
            interp_in = 1'b0;
            val_l_in  = base_l;
            val_r_in  = base_r;
            state_in  = lrf_pkg::ST_ADV;
            if (!off_full[lrf_pkg::COUNT_BITS] && (off_full != '0)) begin
               if (off_big) begin
                  val_l_in = '0;
                  val_r_in = '0;
               end else begin
                  mul_l_in    = {base_l[SW-1], base_l};
                  mul_r_in    = {base_r[SW-1], base_r};
                  acc_l_in    = '0;
                  acc_r_in    = '0;
                  digits_in   = lrf_pkg::FRAC_BITS'(gain);
                  dcnt_in     = lrf_pkg::DCNT_BITS'(lrf_pkg::FADE_DIGITS);
                  mul_fade_in = 1'b1;
                  state_in    = lrf_pkg::ST_MUL;
               end
            end
         end
         lrf_pkg::ST_ADV: begin
            phase_in = phase_ff + lrf_pkg::PHASE_BITS'(step_ff);
            count_in = count_ff + lrf_pkg::COUNT_BITS'(1);
            k_in     = k_ff + lrf_pkg::K_BITS'(1);
            pend_in  = 1'b1;
            state_in = lrf_pkg::ST_CHECK;
         end
         default: begin
            state_in = lrf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lrf_pkg::ST_IDLE;
         step_cfg_ff   <= lrf_pkg::STEP_RESET;
         src_frames_ff <= lrf_pkg::SOURCE_RESET;
         out_frames_ff <= lrf_pkg::OUTPUT_RESET;
         stereo_ff     <= lrf_pkg::STEREO_RESET;
         phase_ff      <= '0;
         prev_l_ff     <= '0;
         prev_r_ff     <= '0;
         index_ff      <= '0;
         count_ff      <= '0;
         k_ff          <= '0;
         copy_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_cfg_ff   <= step_cfg_in;
         src_frames_ff <= src_frames_in;
         out_frames_ff <= out_frames_in;
         stereo_ff     <= stereo_in;
         phase_ff      <= phase_in;
         prev_l_ff     <= prev_l_in;
         prev_r_ff     <= prev_r_in;
         index_ff      <= index_in;
         count_ff      <= count_in;
         k_ff          <= k_in;
         copy_ff       <= copy_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_l_ff     <= cur_l_in;
      cur_r_ff     <= cur_r_in;
      final_ff     <= final_in;
      fstart_ff    <= fstart_in;
      step_ff      <= step_in;
      mul_l_ff     <= mul_l_in;
      mul_r_ff     <= mul_r_in;
      acc_l_ff     <= acc_l_in;
      acc_r_ff     <= acc_r_in;
      digits_ff    <= digits_in;
      dcnt_ff      <= dcnt_in;
      mul_fade_ff  <= mul_fade_in;
      interp_ff    <= interp_in;
      val_l_ff     <= val_l_in;
      val_r_ff     <= val_r_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign req_ready        = (state_ff == lrf_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_left     = rsp_left_ff;
   assign rsp_out_right    = rsp_right_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_end_of_track = rsp_end_ff;

endmodule

`default_nettype wire

// ===== tb/linear_resampler_with_fade_unit_tb.sv =====
module linear_resampler_with_fade_unit_tb;
   import lrf_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_FRAMES = 164;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PRINT_LIMIT   = 100;

   typedef struct packed {
      logic [OUT_BITS-1:0] out_left;
      logic [OUT_BITS-1:0] out_right;
      logic                last_of_run;
      logic                end_of_track;
   } out_frame_t;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_t;

   typedef struct packed {
      row_kind_t             kind;
      csr_index_type         reg_sel;
      logic [31:0]           value;
      logic [IN_BITS-1:0]    left;
      logic [IN_BITS-1:0]    right;
      logic                  typed;
      logic [OUT_BITS-1:0]   typed_left;
      logic [OUT_BITS-1:0]   typed_right;
   } stim_row_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [IN_BITS-1:0]  req_sample_left = '0;
   logic signed [IN_BITS-1:0]  req_sample_right = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_out_left;
   logic signed [OUT_BITS-1:0] rsp_out_right;
   logic                       rsp_last_of_run;
   logic                       rsp_end_of_track;
   logic                       csr_wen = 1'b0;
   csr_index_type              csr_index = CSR_STEP;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   logic [STEP_BITS-1:0]  cfg_step = STEP_RESET;
   logic [31:0]           cfg_source_frames = SOURCE_RESET;
   logic [31:0]           cfg_output_frames = OUTPUT_RESET;
   logic                  cfg_stereo = STEREO_RESET;

   logic [PHASE_BITS-1:0] phase_acc = '0;
   longint                held_left = 0;
   longint                held_right = 0;
   logic [31:0]           frame_index = '0;
   logic [31:0]           emitted_count = '0;

   out_frame_t resampled_q[$];
   out_frame_t head_frame;
   string      field_errors;
   int         error_count = 0;
   int         cycle_count = 0;
   int         stall_run = 0;
   int         burst_left = 0;
   bit         steady_sender = 1'b0;
   bit         settled = 1'b1;

   stim_row_t directed_rows [27] = '{
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h7FFFFF, 24'h800000, 1'b1, 32'h7FFFFF00, 32'h80000000},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h800000, 24'h7FFFFF, 1'b1, 32'h80000000, 32'h7FFFFF00},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h000000, 24'h000000, 1'b1, 32'h00000000, 32'h00000000},
      '{ROW_CSR, CSR_STEREO_MODE, 32'd0, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h123456, 24'hFFFFFF, 1'b1, 32'h12345600, 32'h12345600},
      '{ROW_CSR, CSR_STEREO_MODE, 32'd1, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_SOURCE_FRAMES, 32'd0, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h000005, 24'hFFFFFB, 1'b1, 32'h00000500, 32'hFFFFFB00},
      '{ROW_CSR, CSR_SOURCE_FRAMES, 32'd6, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_OUTPUT_FRAMES, 32'd260, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_STEP, 32'd0, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h7FFFFF, 24'h800000, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h800000, 24'h7FFFFF, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h000000, 24'h000000, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h000001, 24'hFFFFFF, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'hFFFFFF, 24'h000001, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_STEP, 32'h3FFFF, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_SOURCE_FRAMES, 32'd3, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h400000, 24'hC00000, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h555555, 24'hAAAAAA, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_STEP, 32'h20000, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_SOURCE_FRAMES, 32'hFFFFFFFF, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_CSR, CSR_OUTPUT_FRAMES, 32'hFFFFFFFF, 24'h0, 24'h0, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h2AAAAA, 24'h155555, 1'b0, 32'h0, 32'h0},
      '{ROW_FRAME, CSR_STEP, 32'd0, 24'h7FFFFF, 24'h800000, 1'b0, 32'h0, 32'h0}
   };

   linear_resampler_with_fade_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_left     (rsp_out_left),
      .rsp_out_right    (rsp_out_right),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_track (rsp_end_of_track),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint fade_sample(input longint level, input logic [31:0] count);
      logic [31:0] ramp_origin;
      logic [31:0] offset;
      longint      gain;
      ramp_origin = (cfg_output_frames > FADE_LENGTH) ? cfg_output_frames - FADE_LENGTH : '0;
      if (count < ramp_origin) return level;
      offset = count - ramp_origin;
      gain = (offset >= FADE_LENGTH) ? 0 : FADE_LENGTH - offset;
      return (level * gain) >>> GAIN_SHIFT;
   endfunction

   task automatic resample_frame(input logic signed [IN_BITS-1:0] sample_l,
                                 input logic signed [IN_BITS-1:0] sample_r,
                                 input logic typed,
                                 input logic [OUT_BITS-1:0] typed_l,
                                 input logic [OUT_BITS-1:0] typed_r);
      longint                cur_left;
      longint                cur_right;
      longint                mix_left;
      longint                mix_right;
      longint                frac;
      logic [PHASE_BITS-1:0] stride;
      logic [INT_BITS-1:0]   whole;
      logic [31:0]           n;
      logic                  last_frame;
      int                    produced;
      int                    k;
      out_frame_t            batch [MAX_RESULTS];
      cur_left = sample_l;
      if (cfg_stereo) cur_right = sample_r;
      else cur_right = cur_left;
      stride = (cfg_step < MIN_STEP) ? PHASE_BITS'(MIN_STEP) : PHASE_BITS'(cfg_step);
      n = frame_index;
      last_frame = ({1'b0, n} + 33'd1) >= {1'b0, cfg_source_frames};
      produced = 0;
      while (produced < MAX_RESULTS) begin
         whole = phase_acc[PHASE_BITS-1:FRAC_BITS];
         if (n != 0 && whole == n - 32'd1) begin
            frac = phase_acc[FRAC_BITS-1:0];
            mix_left = held_left + (((cur_left - held_left) * frac) >>> FRAC_BITS);
            mix_right = held_right + (((cur_right - held_right) * frac) >>> FRAC_BITS);
         end else if (last_frame && whole == n) begin
            mix_left = cur_left;
            mix_right = cur_right;
         end else begin
            break;
         end
         batch[produced].out_left = OUT_BITS'(fade_sample(mix_left, emitted_count) <<< OUT_PAD);
         batch[produced].out_right = OUT_BITS'(fade_sample(mix_right, emitted_count) <<< OUT_PAD);
         batch[produced].last_of_run = 1'b0;
         batch[produced].end_of_track = 1'b0;
         emitted_count = emitted_count + 32'd1;
         phase_acc = phase_acc + stride;
         produced++;
      end
      if (produced > 0) begin
         batch[produced-1].last_of_run = 1'b1;
         batch[produced-1].end_of_track = last_frame;
         if (typed) begin
            batch[0].out_left = typed_l;
            batch[0].out_right = typed_r;
         end
      end
      for (k = 0; k < produced; k++) resampled_q.push_back(batch[k]);
      if (last_frame) begin
         phase_acc = '0;
         held_left = 0;
         held_right = 0;
         frame_index = '0;
         emitted_count = '0;
      end else begin
         held_left = cur_left;
         held_right = cur_right;
         frame_index = n + 32'd1;
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR at cycle %0d:%s", cycle_count, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (resampled_q.size() == 0) begin
            report_mismatch($sformatf(" unexpected result %h %h", rsp_out_left, rsp_out_right));
         end else begin
            head_frame = resampled_q.pop_front();
            field_errors = "";
            if (rsp_out_left !== head_frame.out_left)
               field_errors = {field_errors, $sformatf(" out_left %h expected %h",
                               rsp_out_left, head_frame.out_left)};
            if (rsp_out_right !== head_frame.out_right)
               field_errors = {field_errors, $sformatf(" out_right %h expected %h",
                               rsp_out_right, head_frame.out_right)};
            if (rsp_last_of_run !== head_frame.last_of_run)
               field_errors = {field_errors, $sformatf(" last_of_run %b expected %b",
                               rsp_last_of_run, head_frame.last_of_run)};
            if (rsp_end_of_track !== head_frame.end_of_track)
               field_errors = {field_errors, $sformatf(" end_of_track %b expected %b",
                               rsp_end_of_track, head_frame.end_of_track)};
            if (field_errors != "") report_mismatch(field_errors);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_run == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_ready <= 1'b1;
               stall_run <= $urandom_range(20, 80);
            end
            1: begin
               rsp_ready <= 1'b0;
               stall_run <= $urandom_range(1, 12);
            end
            default: begin
               rsp_ready <= ~rsp_ready;
               stall_run <= $urandom_range(0, 3);
            end
         endcase
      end else begin
         stall_run <= stall_run - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (resampled_q.size() != 0) @(posedge clock);
   endtask

   task automatic quiesce();
      pause_sender(1);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      settled = 1'b1;
   endtask

   task automatic send_frame(input logic [IN_BITS-1:0] sample_l,
                             input logic [IN_BITS-1:0] sample_r,
                             input logic typed,
                             input logic [OUT_BITS-1:0] typed_l,
                             input logic [OUT_BITS-1:0] typed_r);
      req_valid <= 1'b1;
      req_sample_left <= sample_l;
      req_sample_right <= sample_r;
      settled = 1'b0;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      resample_frame(sample_l, sample_r, typed, typed_l, typed_r);
   endtask

   task automatic offer_frame(input logic [IN_BITS-1:0] sample_l,
                              input logic [IN_BITS-1:0] sample_r,
                              input logic typed,
                              input logic [OUT_BITS-1:0] typed_l,
                              input logic [OUT_BITS-1:0] typed_r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!steady_sender && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
         if ($urandom_range(0, 15) == 0) begin
            pause_sender(1);
            wait_drained();
         end
      end
      burst_left--;
      send_frame(sample_l, sample_r, typed, typed_l, typed_r);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [31:0] value);
      if (!settled) quiesce();
      csr_wen <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (sel)
         CSR_STEP:          cfg_step = value[STEP_BITS-1:0];
         CSR_SOURCE_FRAMES: cfg_source_frames = value;
         CSR_OUTPUT_FRAMES: cfg_output_frames = value;
         CSR_STEREO_MODE:   cfg_stereo = value[0];
         default:           ;
      endcase
   endtask

   function automatic logic [IN_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return '0;
         default: return IN_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int          random_sent;
      int unsigned count;
      logic [31:0] remaining;
      logic [31:0] pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_csr(directed_rows[i].reg_sel, directed_rows[i].value);
         else
            offer_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].typed,
                        directed_rows[i].typed_left, directed_rows[i].typed_right);
      end

      // One long track at the smallest step runs the fade all the way down to zero gain.
      write_csr(CSR_STEP, 32'(MIN_STEP));
      write_csr(CSR_SOURCE_FRAMES, 32'd140);
      write_csr(CSR_OUTPUT_FRAMES, 32'd0);
      write_csr(CSR_STEREO_MODE, 32'd1);
      random_sent = 0;
      repeat (cfg_source_frames - frame_index) begin
         offer_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
         random_sent++;
      end

      while (random_sent < RANDOM_FRAMES) begin
         case ($urandom_range(0, 7))
            0: pick = '0;
            1: pick = 32'(MIN_STEP);
            2: pick = 32'h20000;
            3: pick = 32'h3FFFF;
            4: pick = $urandom_range(0, 32767);
            default: pick = $urandom_range(32768, 131072);
         endcase
         write_csr(CSR_STEP, pick);
         case ($urandom_range(0, 7))
            0: pick = '0;
            1: pick = 32'd1;
            2: pick = 32'hFFFFFFFF;
            default: pick = $urandom_range(2, 10);
         endcase
         write_csr(CSR_SOURCE_FRAMES, pick);
         case ($urandom_range(0, 3))
            0: pick = '0;
            1: pick = 32'hFFFFFFFF;
            2: pick = $urandom_range(1, 300);
            default: pick = $urandom;
         endcase
         write_csr(CSR_OUTPUT_FRAMES, pick);
         write_csr(CSR_STEREO_MODE, 32'($urandom_range(0, 1)));
         steady_sender = ($urandom_range(0, 3) == 0);
         remaining = (cfg_source_frames > frame_index) ? cfg_source_frames - frame_index : 32'd1;
         if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 6);
         else if (remaining > 12) count = $urandom_range(4, 12);
         else count = remaining;
         repeat (count) begin
            offer_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
            random_sent++;
         end
      end

      quiesce();
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== linear_resampler_with_fade_unit.f =====
rtl/core/lrf_pkg.sv
rtl/core/linear_resampler_with_fade_unit.sv
tb/linear_resampler_with_fade_unit_tb.sv
